// ===== rtl/kmac_pkg.sv =====
`timescale 1ns / 1ps
package kmac_pkg;

	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int WORD_W  = 64;
	localparam int CNT_W   = 4;
	localparam int LANES   = 25;
	localparam int LIDX_W  = 5;
	localparam int ROUNDS  = 24;
	localparam int RND_W   = 5;
	localparam int BUF_D   = 12;
	localparam int BUFC_W  = 4;

	localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_KEY    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DATA   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CUST = 2'd1;
	localparam logic [1:0] PH_KEY  = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	localparam logic [7:0] LFSR_POLY = 8'h71;
	localparam logic [7:0] SUFFIX_LO = 8'h04;
	localparam logic [7:0] SUFFIX_HI = 8'h80;

	typedef logic [LANES-1:0][WORD_W-1:0] sponge_t;

	typedef struct packed {
		logic [WORD_W-1:0] rc;
		logic [7:0]        lfsr;
	} rc_step_t;

	localparam logic [5:0] RHO_OFF [LANES] = '{
		6'd0, 6'd1, 6'd62, 6'd28, 6'd27,
		6'd36, 6'd44, 6'd6, 6'd55, 6'd20,
		6'd3, 6'd10, 6'd43, 6'd25, 6'd39,
		6'd41, 6'd45, 6'd15, 6'd21, 6'd8,
		6'd18, 6'd2, 6'd61, 6'd56, 6'd14
	};

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
		input logic [5:0] s);
		logic [2*WORD_W-1:0] d;
		d = {v, v} << s;
		return d[2*WORD_W-1:WORD_W];
	endfunction

	// Seven LFSR steps give the round constant bits at positions 2^j - 1.
	function automatic rc_step_t round_const(input logic [7:0] lfsr_in);
		rc_step_t r;
		logic [7:0] l;
		l = lfsr_in;
		r.rc = '0;
		for (int j = 0; j < 7; j++) begin
			if (l[0]) begin
				r.rc[(1 << j) - 1] = 1'b1;
			end
			l = (l << 1) ^ (l[7] ? LFSR_POLY : 8'h00);
		end
		r.lfsr = l;
		return r;
	endfunction

	function automatic sponge_t keccak_round(input sponge_t a_in,
		input logic [WORD_W-1:0] rc);
		sponge_t a;
		sponge_t b;
		logic [4:0][WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		a = a_in;
		for (int x = 0; x < 5; x++) begin
			c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
		end
		for (int x = 0; x < 5; x++) begin
			d = c[(x+4)%5] ^ rotl(c[(x+1)%5], 6'd1);
			for (int y = 0; y < 5; y++) begin
				a[x+5*y] = a[x+5*y] ^ d;
			end
		end
		for (int y = 0; y < 5; y++) begin
			for (int x = 0; x < 5; x++) begin
				b[y+5*((2*x+3*y)%5)] = rotl(a[x+5*y], RHO_OFF[x+5*y]);
			end
		end
		for (int y = 0; y < 5; y++) begin
			for (int x = 0; x < 5; x++) begin
				a[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
			end
		end
		a[0] = a[0] ^ rc;
		return a;
	endfunction

endpackage

// ===== rtl/kmac_in_if.sv =====
`timescale 1ns / 1ps
interface kmac_in_if;
	logic                          valid;
	logic                          ready;
	logic [kmac_pkg::CMD_W-1:0]    command;
	logic [kmac_pkg::BYTE_W-1:0]   data_byte;
	logic [kmac_pkg::LEN_W-1:0]    length;

	modport source (output valid, command, data_byte, length, input ready);
	modport sink   (input valid, command, data_byte, length, output ready);
endinterface

// ===== rtl/kmac_out_if.sv =====
`timescale 1ns / 1ps
interface kmac_out_if;
	logic                          valid;
	logic                          ready;
	logic [kmac_pkg::WORD_W-1:0]   out_word;
	logic [kmac_pkg::CNT_W-1:0]    byte_count;
	logic                          status;
	logic                          last;

	modport source (output valid, out_word, byte_count, status, last, input ready);
	modport sink   (input valid, out_word, byte_count, status, last, output ready);
endinterface

// ===== rtl/kmac256_engine.sv =====
`timescale 1ns / 1ps
// An absorbing command absorbs its staged bytes in S_LOAD, then presents its result
// beat from S_ACK and is ready again; data start goes to S_ACK without absorbing.
// Padding to the block end and each filled block add a permutation of 24 rounds.
// Finish then adds the suffix and runs the permutation, then squeezes the output bytes
// into beats, with a permutation per further block; result stalls add to all.
// arst_n clears the sponge state, position, phase and all handshake state at once.
module kmac256_engine #(
	parameter int RATE_BYTES    = 136,
	parameter int MAX_OUT_WORDS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	kmac_in_if.sink          cmd_ch,
	kmac_out_if.source       res_ch
);
	import kmac_pkg::*;

	localparam int POS_W   = $clog2(RATE_BYTES + 1);
	localparam int MAX_LEN = MAX_OUT_WORDS * 8;
	localparam int REM_W   = $clog2(MAX_LEN + 1);
	localparam int HI_LANE = (RATE_BYTES - 1) / 8;
	localparam int HI_SH   = 8 * ((RATE_BYTES - 1) % 8);

	// Sequencer states: idle, byte absorption from the staging buffer, one
	// permutation round per cycle, suffix padding, squeezing, and the
	// acknowledgement beat.
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOAD   = 6'b000010,
		S_PERM   = 6'b000100,
		S_SUFFIX = 6'b001000,
		S_SQZ    = 6'b010000,
		S_ACK    = 6'b100000
	} state_t;

	state_t                 state_q, ret_q;
	sponge_t                lanes_q;
	logic [POS_W-1:0]       pos_q;
	logic [1:0]             phase_q;
	logic [RND_W-1:0]       rnd_q;
	logic [7:0]             lfsr_q;
	logic [BYTE_W-1:0]      buf_q [BUF_D];
	logic [BUFC_W-1:0]      bufc_q;
	logic                   fin_q;
	logic                   err_q;
	logic [REM_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [WORD_W-1:0]      word_q;

	logic                   out_valid_q;
	logic [WORD_W-1:0]      out_word_q;
	logic [CNT_W-1:0]       out_cnt_q;
	logic                   out_status_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic                   reject;
	logic [LEN_W+2:0]       len8;
	logic [1:0]             enc_n;
	logic [BYTE_W-1:0]      nbuf [BUF_D];
	logic [BUFC_W-1:0]      nbufc;
	logic [LIDX_W-1:0]      lane_idx;
	logic [5:0]             byte_sh;
	logic [BYTE_W-1:0]      sq_byte;
	rc_step_t               rcs;
	logic                   word_done;

	assign accept   = cmd_ch.valid && cmd_ch.ready;
	assign out_free = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);

	// A new result beat is loaded into the output register this cycle.
	assign out_load = out_free && ((state_q == S_ACK) || (state_q == S_SQZ && word_done));

	assign res_ch.valid      = out_valid_q;
	assign res_ch.out_word   = out_word_q;
	assign res_ch.byte_count = out_cnt_q;
	assign res_ch.status     = out_status_q;
	assign res_ch.last       = out_last_q;

	assign lane_idx  = LIDX_W'(pos_q >> 3);
	assign byte_sh   = {pos_q[2:0], 3'b000};
	assign sq_byte   = BYTE_W'(lanes_q[lane_idx] >> byte_sh);
	assign rcs       = round_const(lfsr_q);
	assign word_done = (cnt_q == CNT_W'(8)) || (rem_q == '0);

	// The encoded length in bits needs one to three bytes.
	assign len8  = {cmd_ch.length, 3'b000};
	assign enc_n = (len8[18:16] != '0) ? 2'd3 : ((len8[15:8] != '0) ? 2'd2 : 2'd1);

	always_comb begin
		case (cmd_ch.command)
			CMD_START:  reject = 1'b0;
			CMD_BYTE:   reject = (phase_q == PH_IDLE);
			CMD_KEY:    reject = (phase_q != PH_CUST);
			CMD_DATA:   reject = (phase_q != PH_KEY);
			CMD_FINISH: reject = (phase_q != PH_DATA) || (cmd_ch.length == '0) ||
				(32'(cmd_ch.length) > 32'(MAX_LEN));
			default:    reject = 1'b1;
		endcase
	end

	// Staging buffer of bytes to absorb for the accepted command.
	always_comb begin
		for (int i = 0; i < BUF_D; i++) begin
			nbuf[i] = '0;
		end
		nbufc = '0;
		case (cmd_ch.command)
			CMD_START: begin
				nbuf[0] = 8'd1;
				nbuf[1] = 8'(RATE_BYTES);
				nbuf[2] = 8'd1;
				nbuf[3] = 8'd32;
				nbuf[4] = 8'h4B;
				nbuf[5] = 8'h4D;
				nbuf[6] = 8'h41;
				nbuf[7] = 8'h43;
				nbuf[8] = {6'd0, enc_n};
				case (enc_n)
					2'd3: begin
						nbuf[9]  = {5'd0, len8[18:16]};
						nbuf[10] = len8[15:8];
						nbuf[11] = len8[7:0];
					end
					2'd2: begin
						nbuf[9]  = len8[15:8];
						nbuf[10] = len8[7:0];
					end
					default: nbuf[9] = len8[7:0];
				endcase
				nbufc = BUFC_W'(9) + BUFC_W'(enc_n);
			end
			CMD_BYTE: begin
				nbuf[0] = cmd_ch.data_byte;
				nbufc   = BUFC_W'(1);
			end
			CMD_KEY: begin
				nbuf[0] = 8'd1;
				nbuf[1] = 8'(RATE_BYTES);
				nbuf[2] = {6'd0, enc_n};
				case (enc_n)
					2'd3: begin
						nbuf[3] = {5'd0, len8[18:16]};
						nbuf[4] = len8[15:8];
						nbuf[5] = len8[7:0];
					end
					2'd2: begin
						nbuf[3] = len8[15:8];
						nbuf[4] = len8[7:0];
					end
					default: nbuf[3] = len8[7:0];
				endcase
				nbufc = BUFC_W'(3) + BUFC_W'(enc_n);
			end
			CMD_FINISH: begin
				// Right encoding: the value bytes come first, then their count.
				if (enc_n == 2'd2) begin
					nbuf[0] = len8[15:8];
					nbuf[1] = len8[7:0];
					nbuf[2] = 8'd2;
					nbufc   = BUFC_W'(3);
				end else begin
					nbuf[0] = len8[7:0];
					nbuf[1] = 8'd1;
					nbufc   = BUFC_W'(2);
				end
			end
			default: nbufc = '0;
		endcase
	end

	// Staging buffer is a plain shift line read at its head only.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			buf_q <= nbuf;
		end else if (state_q == S_LOAD && bufc_q != '0) begin
			for (int i = 0; i < BUF_D - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[BUF_D-1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			lanes_q      <= '0;
			pos_q        <= '0;
			phase_q      <= PH_IDLE;
			rnd_q        <= '0;
			lfsr_q       <= 8'd1;
			bufc_q       <= '0;
			fin_q        <= 1'b0;
			err_q        <= 1'b0;
			rem_q        <= '0;
			cnt_q        <= '0;
			word_q       <= '0;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			out_cnt_q    <= '0;
			out_status_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && res_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bufc_q <= nbufc;
						fin_q  <= (cmd_ch.command == CMD_FINISH);
						err_q  <= reject;
						rem_q  <= REM_W'(cmd_ch.length);
						if (reject) begin
							state_q <= S_ACK;
						end else begin
							case (cmd_ch.command)
								CMD_START: begin
									lanes_q <= '0;
									pos_q   <= '0;
									phase_q <= PH_CUST;
									state_q <= S_LOAD;
								end
								CMD_KEY, CMD_DATA: begin
									// Zero padding to the block end only moves the
									// position, so it reduces to one permutation.
									phase_q <= (cmd_ch.command == CMD_KEY) ? PH_KEY : PH_DATA;
									ret_q   <= (cmd_ch.command == CMD_KEY) ? S_LOAD : S_ACK;
									if (pos_q != '0) begin
										pos_q   <= '0;
										rnd_q   <= '0;
										lfsr_q  <= 8'd1;
										state_q <= S_PERM;
									end else begin
										state_q <= (cmd_ch.command == CMD_KEY) ? S_LOAD : S_ACK;
									end
								end
								default: state_q <= S_LOAD;
							endcase
						end
					end
				end
				S_LOAD: begin
					if (bufc_q == '0) begin
						state_q <= fin_q ? S_SUFFIX : S_ACK;
					end else begin
						lanes_q[lane_idx] <= lanes_q[lane_idx] ^
							(WORD_W'(buf_q[0]) << byte_sh);
						bufc_q <= bufc_q - 1'b1;
						if (32'(pos_q) + 1 == RATE_BYTES) begin
							pos_q   <= '0;
							rnd_q   <= '0;
							lfsr_q  <= 8'd1;
							ret_q   <= S_LOAD;
							state_q <= S_PERM;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_PERM: begin
					lanes_q <= keccak_round(lanes_q, rcs.rc);
					lfsr_q  <= rcs.lfsr;
					rnd_q   <= rnd_q + 1'b1;
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						state_q <= ret_q;
					end
				end
				S_SUFFIX: begin
					// Domain suffix at the current position, final pad bit at
					// the last byte of the block; they may share a byte.
					for (int i = 0; i < LANES; i++) begin
						lanes_q[i] <= lanes_q[i] ^
							((LIDX_W'(i) == lane_idx) ? (WORD_W'(SUFFIX_LO) << byte_sh) : '0) ^
							((i == HI_LANE) ? (WORD_W'(SUFFIX_HI) << HI_SH) : '0);
					end
					pos_q   <= '0;
					cnt_q   <= '0;
					word_q  <= '0;
					phase_q <= PH_IDLE;
					rnd_q   <= '0;
					lfsr_q  <= 8'd1;
					ret_q   <= S_SQZ;
					state_q <= S_PERM;
				end
				S_SQZ: begin
					if (word_done) begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							out_word_q   <= word_q;
							out_cnt_q    <= cnt_q;
							out_status_q <= 1'b0;
							out_last_q   <= (rem_q == '0);
							cnt_q        <= '0;
							word_q       <= '0;
							if (rem_q == '0) begin
								state_q <= S_IDLE;
							end
						end
					end else if (32'(pos_q) == RATE_BYTES) begin
						pos_q   <= '0;
						rnd_q   <= '0;
						lfsr_q  <= 8'd1;
						ret_q   <= S_SQZ;
						state_q <= S_PERM;
					end else begin
						word_q <= word_q | (WORD_W'(sq_byte) << {cnt_q[2:0], 3'b000});
						cnt_q  <= cnt_q + 1'b1;
						rem_q  <= rem_q - 1'b1;
						pos_q  <= pos_q + 1'b1;
					end
				end
				S_ACK: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_word_q   <= '0;
						out_cnt_q    <= '0;
						out_status_q <= err_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
